>>> src/lrb_pkg.sv
// Package for the link reconnect backoff block.
// Holds the state codes, register indexes, field widths and the shared structs.
// Depends on nothing.
package lrb_pkg;

    localparam int COUNT_BITS = 16;

    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = 17;

    localparam logic [CFG_IDX_BITS-1:0] REG_SERVICE_PERIOD = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_CONNECT_WAIT   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_RETRY_START    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_RETRY_MAX      = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_FAILURE_TIME   = 3'd4;

    localparam logic [2:0] ST_SETUP     = 3'd0;
    localparam logic [2:0] ST_CONNECT   = 3'd1;
    localparam logic [2:0] ST_WAIT      = 3'd2;
    localparam logic [2:0] ST_CONNECTED = 3'd3;
    localparam logic [2:0] ST_TIMEOUT   = 3'd4;
    localparam logic [2:0] ST_RADIO_OFF = 3'd5;

    localparam logic [9:0]  RST_SERVICE_PERIOD = 10'd100;
    localparam logic [15:0] RST_CONNECT_WAIT   = 16'd15000;
    localparam logic [7:0]  RST_RETRY_START    = 8'd4;
    localparam logic [7:0]  RST_RETRY_MAX      = 8'd64;
    localparam logic [26:0] RST_FAIL_LIMIT_MS  = 27'd7200000;
    localparam logic [9:0]  MS_PER_S           = 10'd1000;

    typedef struct packed {
        logic [9:0]  service_period;
        logic [15:0] connect_wait;
        logic [7:0]  retry_start;
        logic [7:0]  retry_max;
        logic [26:0] fail_limit_ms;
    } t_cfg;

    typedef struct packed {
        logic [2:0]  conn_state;
        logic        do_setup;
        logic        do_connect;
        logic        radio_off;
        logic        radio_on;
        logic        is_connected;
        logic        link_failure;
        logic [15:0] connect_count;
        logic [15:0] timeout_count;
    } t_result;

endpackage

>>> src/lrb_cfg.sv
// Configuration register file for the link reconnect backoff block.
// Also converts the failure time to milliseconds once at write time.
// Depends on lrb_pkg.
module lrb_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_wr,
    input  logic [lrb_pkg::CFG_IDX_BITS-1:0]  i_idx,
    input  logic [lrb_pkg::CFG_DATA_BITS-1:0] i_data,
    output lrb_pkg::t_cfg                     o_cfg
);
    import lrb_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.service_period <= RST_SERVICE_PERIOD;
            r_cfg.connect_wait   <= RST_CONNECT_WAIT;
            r_cfg.retry_start    <= RST_RETRY_START;
            r_cfg.retry_max      <= RST_RETRY_MAX;
            r_cfg.fail_limit_ms  <= RST_FAIL_LIMIT_MS;
        end else if (i_wr) begin
            case (i_idx)
                REG_SERVICE_PERIOD: r_cfg.service_period <= i_data[9:0];
                REG_CONNECT_WAIT:   r_cfg.connect_wait   <= i_data[15:0];
                REG_RETRY_START:    r_cfg.retry_start    <= i_data[7:0];
                REG_RETRY_MAX:      r_cfg.retry_max      <= i_data[7:0];
                REG_FAILURE_TIME:   r_cfg.fail_limit_ms  <=
                    {10'd0, i_data[16:0]} * {17'd0, MS_PER_S};
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> src/lrb_core.sv
// State registers and one-tick update logic of the link manager.
// Produces the result of the tick held in the input register.
// Depends on lrb_pkg.
module lrb_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic             i_link,
    input  lrb_pkg::t_cfg    i_cfg,
    output lrb_pkg::t_result o_res
);
    import lrb_pkg::*;

    logic [2:0]            r_state, n_state;
    logic [9:0]            r_svc, n_svc;
    logic [15:0]           r_attempt, n_attempt;
    logic [19:0]           r_radio, n_radio;
    logic [8:0]            r_retry, n_retry;
    logic                  r_lost_active, n_lost_active;
    logic [26:0]           r_lost, n_lost;
    logic [COUNT_BITS-1:0] r_conns, n_conns;
    logic [COUNT_BITS-1:0] r_tmos, n_tmos;
    logic [9:0]            svc_inc;
    logic                  eval;
    logic                  conn;
    logic [31:0]           conns_ext;
    logic [31:0]           tmos_ext;

    always_comb begin
        n_attempt     = (r_attempt != '1) ? r_attempt + 16'd1 : r_attempt;
        n_radio       = (r_radio != '0) ? r_radio - 20'd1 : r_radio;
        n_lost        = (r_lost_active && r_lost != '1) ? r_lost + 27'd1 : r_lost;
        n_lost_active = r_lost_active;
        n_state       = r_state;
        n_retry       = r_retry;
        n_conns       = r_conns;
        n_tmos        = r_tmos;
        svc_inc       = r_svc + 10'd1;
        eval          = (svc_inc >= i_cfg.service_period) || (svc_inc == '0);
        n_svc         = eval ? '0 : svc_inc;
        o_res         = '0;

        if (eval) begin
            case (r_state)
                ST_SETUP: begin
                    o_res.do_setup = 1'b1;
                    n_state        = ST_CONNECT;
                end
                ST_CONNECT: begin
                    o_res.do_connect = 1'b1;
                    n_attempt        = '0;
                    n_state          = ST_WAIT;
                end
                ST_WAIT: begin
                    if (i_link) begin
                        n_conns       = (r_conns != '1) ? r_conns + 1'b1 : r_conns;
                        n_state       = ST_CONNECTED;
                        n_retry       = {1'b0, i_cfg.retry_start};
                        n_lost_active = 1'b0;
                        n_lost        = '0;
                    end else if (n_attempt >= i_cfg.connect_wait) begin
                        n_state = ST_TIMEOUT;
                    end
                end
                ST_CONNECTED: begin
                    if (!i_link) begin
                        n_state       = ST_SETUP;
                        n_lost_active = 1'b1;
                        n_lost        = '0;
                    end
                end
                ST_TIMEOUT: begin
                    n_tmos          = (r_tmos != '1) ? r_tmos + 1'b1 : r_tmos;
                    o_res.radio_off = 1'b1;
                    n_radio         = {1'b0, {10'd0, r_retry} * {9'd0, MS_PER_S}};
                    if (r_retry < {1'b0, i_cfg.retry_max}) begin
                        n_retry = {r_retry[7:0], 1'b0};
                    end
                    n_state = ST_RADIO_OFF;
                end
                ST_RADIO_OFF: begin
                    if (n_radio == '0) begin
                        o_res.radio_on = 1'b1;
                        n_state        = ST_SETUP;
                    end
                end
                default: ;
            endcase
        end

        conn      = (n_state == ST_CONNECTED) && i_link;
        conns_ext = 32'(n_conns);
        tmos_ext  = 32'(n_tmos);

        o_res.conn_state    = n_state;
        o_res.is_connected  = conn;
        o_res.link_failure  = !conn && n_lost_active && (n_lost > i_cfg.fail_limit_ms);
        o_res.connect_count = (conns_ext > 32'hFFFF) ? 16'hFFFF : conns_ext[15:0];
        o_res.timeout_count = (tmos_ext > 32'hFFFF) ? 16'hFFFF : tmos_ext[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_SETUP;
            r_svc         <= '0;
            r_attempt     <= '0;
            r_radio       <= '0;
            r_retry       <= {1'b0, RST_RETRY_START};
            r_lost_active <= 1'b0;
            r_lost        <= '0;
            r_conns       <= '0;
            r_tmos        <= '0;
        end else if (i_step) begin
            r_state       <= n_state;
            r_svc         <= n_svc;
            r_attempt     <= n_attempt;
            r_radio       <= n_radio;
            r_retry       <= n_retry;
            r_lost_active <= n_lost_active;
            r_lost        <= n_lost;
            r_conns       <= n_conns;
            r_tmos        <= n_tmos;
        end
    end

endmodule

>>> src/link_reconnect_backoff_fsm.sv
// Top level of the link reconnect backoff block.
// Holds the input and result registers and the handshakes; uses lrb_pkg, lrb_cfg, lrb_core.
//
// Each item is one millisecond tick with the link status. An accepted item is held in the
// input register, and its result is loaded into the result register when the state update
// advances, which an output stall can hold off; while the output is not stalled, a new item
// can be accepted in every cycle. The result register holds while the output is stalled, and
// the input register fills behind it, so the block stalls its input only when both are
// occupied. Configuration writes are always ready and take effect from the next cycle;
// write only while idle.
module link_reconnect_backoff_fsm (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_link_up,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [2:0]                        o_conn_state,
    output logic                              o_do_setup,
    output logic                              o_do_connect,
    output logic                              o_radio_off,
    output logic                              o_radio_on,
    output logic                              o_is_connected,
    output logic                              o_link_failure,
    output logic [15:0]                       o_connect_count,
    output logic [15:0]                       o_timeout_count,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [lrb_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [lrb_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);
    import lrb_pkg::*;

    logic    r_in_valid;
    logic    r_in_link;
    logic    r_out_valid;
    t_result r_res;
    t_result step_res;
    t_cfg    cfg;
    logic    advance;
    logic    in_take;

    assign advance     = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall     = r_in_valid && !advance;
    assign in_take     = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    lrb_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid),
        .i_idx   (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    lrb_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_link  (r_in_link),
        .i_cfg   (cfg),
        .o_res   (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_link <= i_link_up;
        end
        if (advance) begin
            r_res <= step_res;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_conn_state    = r_res.conn_state;
    assign o_do_setup      = r_res.do_setup;
    assign o_do_connect    = r_res.do_connect;
    assign o_radio_off     = r_res.radio_off;
    assign o_radio_on      = r_res.radio_on;
    assign o_is_connected  = r_res.is_connected;
    assign o_link_failure  = r_res.link_failure;
    assign o_connect_count = r_res.connect_count;
    assign o_timeout_count = r_res.timeout_count;

endmodule

>>> src/lrb_checker.sv
// Port-level checker for the link reconnect backoff block, bound to the top level.
// Depends on lrb_pkg.
module lrb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [2:0]  o_conn_state,
    input logic        o_do_setup,
    input logic        o_do_connect,
    input logic        o_radio_off,
    input logic        o_radio_on,
    input logic        o_is_connected,
    input logic        o_link_failure
);
    import lrb_pkg::*;

    a_one_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $onehot0({o_do_setup, o_do_connect, o_radio_off, o_radio_on}))
        else $error("more than one action pulse in one item");

    a_conn_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_connected) |-> (o_conn_state == ST_CONNECTED && !o_link_failure))
        else $error("connected status disagrees with state or failure flag");

    a_setup_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_do_setup) |-> (o_conn_state == ST_CONNECT))
        else $error("setup pulse without move to connect");

    a_off_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_radio_off) |-> (o_conn_state == ST_RADIO_OFF))
        else $error("radio-off pulse without move to radio-off wait");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_conn_state)))
        else $error("stalled item changed");

endmodule

bind link_reconnect_backoff_fsm lrb_checker u_lrb_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_conn_state   (o_conn_state),
    .o_do_setup     (o_do_setup),
    .o_do_connect   (o_do_connect),
    .o_radio_off    (o_radio_off),
    .o_radio_on     (o_radio_on),
    .o_is_connected (o_is_connected),
    .o_link_failure (o_link_failure)
);
